// ===== src/sem_pkg.sv =====
// Shared types and constants for the streaming Sobel edge magnitude block.
// Used by sem_scan, sem_win and sobel_edge_magnitude_stream; no dependencies.
package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned ROW_W   = 12;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned IMG_W_W = 11;
  localparam int unsigned IMG_H_W = 13;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [IMG_W_W-1:0] IMG_W_RST = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] IMG_H_RST = IMG_H_W'(480);
  localparam logic [IMG_H_W-1:0] IMG_H_MAX = IMG_H_W'(4096);
  localparam int unsigned        SIZE_MIN  = 3;
  localparam logic [PIX_W-1:0]   EDGE_MAX  = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-pixel control that travels down the pipeline.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

// ===== src/sem_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
module sem_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/sem_scan.sv =====
// Frame scan: image size registers, column/row counters, per-pixel position.
// Depends on sem_pkg.
module sem_scan #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [sem_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                advance,
  output logic [$clog2(MAX_WIDTH)-1:0]        addr,
  output sem_pkg::pos_t                       pos
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned LW0 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW  = (LW0 > sem_pkg::IMG_W_W) ? LW0 : sem_pkg::IMG_W_W;
  localparam int unsigned OW  = (CW > sem_pkg::COL_W) ? CW : sem_pkg::COL_W;
  localparam int unsigned HW  = sem_pkg::IMG_H_W;

  logic [sem_pkg::IMG_W_W-1:0] img_w_r;
  logic [HW-1:0]               img_h_r;
  logic [CW-1:0]               col_r, col_nxt;
  logic [sem_pkg::ROW_W-1:0]   row_r, row_nxt;

  logic [LW-1:0] w_raw, w_eff, col_inc;
  logic [HW-1:0] h_eff, row_inc;
  logic [OW-1:0] col_m1;
  logic          row_end, col_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= sem_pkg::IMG_W_RST;
      img_h_r <= sem_pkg::IMG_H_RST;
    end else if (cfg_we) begin
      unique case (sem_pkg::cfg_reg_t'(cfg_idx))
        sem_pkg::REG_IMAGE_WIDTH:  img_w_r <= cfg_data[sem_pkg::IMG_W_W-1:0];
        sem_pkg::REG_IMAGE_HEIGHT: img_h_r <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = LW'(img_w_r);
    if (w_raw < LW'(sem_pkg::SIZE_MIN)) begin
      w_eff = LW'(sem_pkg::SIZE_MIN);
    end else if (w_raw > LW'(MAX_WIDTH)) begin
      w_eff = LW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end

    if (img_h_r < HW'(sem_pkg::SIZE_MIN)) begin
      h_eff = HW'(sem_pkg::SIZE_MIN);
    end else if (img_h_r > sem_pkg::IMG_H_MAX) begin
      h_eff = sem_pkg::IMG_H_MAX;
    end else begin
      h_eff = img_h_r;
    end

    col_inc = LW'(col_r) + LW'(1);
    row_inc = HW'(row_r) + HW'(1);
    col_end = (col_inc >= w_eff);
    row_end = (row_inc >= h_eff);
    col_m1  = OW'(col_r) - OW'(1);

    pos.emit = (row_r >= sem_pkg::ROW_W'(2)) && (col_r >= CW'(2));
    pos.last = row_end && col_end;
    pos.row  = row_r - sem_pkg::ROW_W'(1);
    pos.col  = col_m1[sem_pkg::COL_W-1:0];

    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : row_inc[sem_pkg::ROW_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign addr = col_r;

endmodule

// ===== src/sem_win.sv =====
// Window pipeline: line store write-back, 3x3 window, Sobel gradients,
// L1 magnitude with clamp and the output register. Depends on sem_pkg.
module sem_win #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_fire,
  input  logic [sem_pkg::PIX_W-1:0]         in_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0]      in_addr,
  input  sem_pkg::pos_t                     in_pos,
  output logic                              in_ready,
  input  logic [2*sem_pkg::PIX_W-1:0]       ls_rdata,
  output logic                              ls_we,
  output logic [$clog2(MAX_WIDTH)-1:0]      ls_waddr,
  output logic [2*sem_pkg::PIX_W-1:0]       ls_wdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sem_pkg::PIX_W-1:0]         out_edge_res,
  output sem_pkg::pos_t                     out_pos
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = sem_pkg::PIX_W;
  localparam int unsigned GW = PW + 3;

  // stage 1: line store data arrives
  logic                s1_valid_r;
  logic [PW-1:0]       s1_px_r;
  logic [CW-1:0]       s1_addr_r;
  sem_pkg::pos_t       s1_pos_r;
  // stage 2: gradients
  logic                s2_valid_r;
  logic signed [GW-1:0] s2_gx_r, s2_gy_r;
  sem_pkg::pos_t       s2_pos_r;
  // output register
  logic                out_valid_r;
  logic [PW-1:0]       out_edge_r;
  sem_pkg::pos_t       out_pos_r;

  logic [PW-1:0] win_r   [9];
  logic [PW-1:0] win_nxt [9];

  logic [PW-1:0] ls_a, ls_b;
  logic          out_ready, s2_go, s2_ready, s1_go;
  logic [GW-2:0] gx_p, gx_n, gy_p, gy_n;
  logic signed [GW-1:0] gx, gy;
  logic [GW-2:0] abs_x, abs_y;
  logic [GW-1:0] mag;
  logic [PW-1:0] edge_nxt;

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_go     = s2_valid_r && (!s2_pos_r.emit || out_ready);
  assign s2_ready  = !s2_valid_r || s2_go;
  assign s1_go     = s1_valid_r && s2_ready;
  assign in_ready  = !s1_valid_r || s1_go;

  assign ls_a     = ls_rdata[2*PW-1:PW];
  assign ls_b     = ls_rdata[PW-1:0];
  assign ls_we    = s1_go;
  assign ls_waddr = s1_addr_r;
  assign ls_wdata = {s1_px_r, ls_a};

  // win[row*3+col]: row 0 oldest line, col 2 newest column
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3+0] = win_r[k*3+1];
      win_nxt[k*3+1] = win_r[k*3+2];
    end
    win_nxt[2] = ls_b;
    win_nxt[5] = ls_a;
    win_nxt[8] = s1_px_r;

    gx_p = (GW-1)'(win_nxt[0]) + {(GW-2)'(win_nxt[3]), 1'b0} + (GW-1)'(win_nxt[6]);
    gx_n = (GW-1)'(win_nxt[2]) + {(GW-2)'(win_nxt[5]), 1'b0} + (GW-1)'(win_nxt[8]);
    gy_p = (GW-1)'(win_nxt[0]) + {(GW-2)'(win_nxt[1]), 1'b0} + (GW-1)'(win_nxt[2]);
    gy_n = (GW-1)'(win_nxt[6]) + {(GW-2)'(win_nxt[7]), 1'b0} + (GW-1)'(win_nxt[8]);
    gx   = $signed({1'b0, gx_p}) - $signed({1'b0, gx_n});
    gy   = $signed({1'b0, gy_p}) - $signed({1'b0, gy_n});
  end

  always_comb begin
    abs_x = s2_gx_r[GW-1] ? (GW-1)'(-s2_gx_r) : s2_gx_r[GW-2:0];
    abs_y = s2_gy_r[GW-1] ? (GW-1)'(-s2_gy_r) : s2_gy_r[GW-2:0];
    mag   = GW'(abs_x) + GW'(abs_y);
    edge_nxt = (mag > GW'(sem_pkg::EDGE_MAX)) ? sem_pkg::EDGE_MAX : mag[PW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 9; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_r <= 1'b1;
        for (int k = 0; k < 9; k++) begin
          win_r[k] <= win_nxt[k];
        end
      end else if (s2_go) begin
        s2_valid_r <= 1'b0;
      end
      if (s2_go && s2_pos_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r   <= in_pixel;
      s1_addr_r <= in_addr;
      s1_pos_r  <= in_pos;
    end
    if (s1_go) begin
      s2_gx_r  <= gx;
      s2_gy_r  <= gy;
      s2_pos_r <= s1_pos_r;
    end
    if (s2_go && s2_pos_r.emit) begin
      out_edge_r <= edge_nxt;
      out_pos_r  <= s2_pos_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_edge_res = out_edge_r;
  assign out_pos      = out_pos_r;

endmodule

// ===== src/sobel_edge_magnitude_stream.sv =====
// Path: a pixel's request passes stage 1, stage 2 and the output register before its result shows on out_valid.
// Throughput: one pixel per cycle; the line store RAM takes one read and one
//   write each cycle, and stalls back up through a three-stage valid chain.
// Reset: counters cleared, size 640x480, window zero; line stores not cleared.
// Depends on sem_pkg, sem_scan, sem_ram, sem_win.
module sobel_edge_magnitude_stream #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [sem_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sem_pkg::PIX_W-1:0]     in_pixel,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sem_pkg::PIX_W-1:0]     out_edge_res,
  output logic [sem_pkg::ROW_W-1:0]     out_row,
  output logic [sem_pkg::COL_W-1:0]     out_col,
  output logic                          out_last
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned LSW = 2 * sem_pkg::PIX_W;

  logic                in_ready, in_fire;
  logic [CW-1:0]       scan_addr, ls_waddr;
  sem_pkg::pos_t       scan_pos, res_pos;
  logic                ls_we;
  logic [LSW-1:0]      ls_wdata, ls_rdata;

  assign in_fire  = in_valid && in_ready;
  assign in_stall = !in_ready;

  sem_scan #(.MAX_WIDTH(MAX_WIDTH)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .advance  (in_fire),
    .addr     (scan_addr),
    .pos      (scan_pos)
  );

  // {previous row, row before that} per column
  sem_ram #(.WIDTH(LSW), .DEPTH(MAX_WIDTH)) u_line_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .re    (in_fire),
    .raddr (scan_addr),
    .rdata (ls_rdata)
  );

  sem_win #(.MAX_WIDTH(MAX_WIDTH)) u_win (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_pixel     (in_pixel),
    .in_addr      (scan_addr),
    .in_pos       (scan_pos),
    .in_ready     (in_ready),
    .ls_rdata     (ls_rdata),
    .ls_we        (ls_we),
    .ls_waddr     (ls_waddr),
    .ls_wdata     (ls_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_edge_res (out_edge_res),
    .out_pos      (res_pos)
  );

  assign out_row  = res_pos.row;
  assign out_col  = res_pos.col;
  assign out_last = res_pos.last;

endmodule
